// ----- hw/rtl/clr_pkg.sv -----
// Shared constants for the clipped line rasterizer: sizes, line modes,
// result status codes and configuration register indexes. No dependencies.
`default_nettype none

package clr_pkg;

    localparam int DIM_BITS         = 11;
    localparam int COORD_BITS_DEF   = 12;
    localparam int COLOR_BITS       = 16;
    localparam int STATUS_BITS      = 2;
    localparam int CFG_ADDR_BITS    = 4;
    localparam int CFG_DATA_BITS    = 32;

    localparam logic [DIM_BITS-1:0] NATIVE_WIDTH_RST  = 11'd240;
    localparam logic [DIM_BITS-1:0] NATIVE_HEIGHT_RST = 11'd320;
    localparam logic [1:0]          ROTATION_RST      = 2'd0;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_HRUN  = 2'd1;
    localparam logic [1:0] MODE_VRUN  = 2'd2;
    localparam logic [1:0] MODE_SLOPE = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_PIXEL_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_INVALID    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOTHING    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_IDLE_STEP  = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] REG_NATIVE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_NATIVE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROTATION      = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/clipped_line_rasterizer_unit.sv -----
// Clipped line rasterizer top level: stream in, stream out, APB registers.
// Depends on clr_pkg.
//
// An item passes through the input register, then the output register; one item
// per cycle unless the output stalls. The line state updates as an item moves
// from the input register to the output register, one add-compare step per item.
// Reset (aresetn low, synchronous): both stages empty, line idle, registers
// back to 240 x 320, rotation 0.
`default_nettype none

module clipped_line_rasterizer_unit
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // first_x, first_y, second_x, second_y, draw_color (lowest bits first)
    input  wire logic [((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  wire logic [0:0]                   s_tuser,

    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pixel_x, pixel_y, pixel_color (lowest bits first)
    output logic [((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8 - 1:0]      m_tdata,
    // pixel_valid, status (lowest bits first)
    output logic [STATUS_BITS:0]              m_tuser,
    output logic                              m_tlast,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0]     paddr,
    input  wire logic [CFG_DATA_BITS-1:0]     pwdata,
    output logic [CFG_DATA_BITS-1:0]          prdata,
    output logic                              pready
);

    localparam int C          = COORD_BITS;
    localparam int OUT_RAW_W  = 2 * C + COLOR_BITS;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int XW         = ((C > DIM_BITS) ? C : DIM_BITS) + 2;
    localparam int EW         = C + 2;

    // configuration
    logic [DIM_BITS-1:0] nat_w_reg, nat_h_reg;
    logic [1:0]          rot_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nat_w_reg <= NATIVE_WIDTH_RST;
            nat_h_reg <= NATIVE_HEIGHT_RST;
            rot_reg   <= ROTATION_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_NATIVE_WIDTH:  nat_w_reg <= pwdata[DIM_BITS-1:0];
                REG_NATIVE_HEIGHT: nat_h_reg <= pwdata[DIM_BITS-1:0];
                REG_ROTATION:      rot_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NATIVE_WIDTH:  prdata = CFG_DATA_BITS'(nat_w_reg);
            REG_NATIVE_HEIGHT: prdata = CFG_DATA_BITS'(nat_h_reg);
            REG_ROTATION:      prdata = CFG_DATA_BITS'(rot_reg);
            default:           prdata = '0;
        endcase
    end

    // input register
    logic                   in_vld_reg;
    logic                   in_op_reg;
    logic signed [C-1:0]    in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;
    logic [COLOR_BITS-1:0]  in_color_reg;
    logic                   advance;
    logic                   out_vld_reg;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser[0];
            in_x0_reg    <= s_tdata[C-1:0];
            in_y0_reg    <= s_tdata[2*C-1:C];
            in_x1_reg    <= s_tdata[3*C-1:2*C];
            in_y1_reg    <= s_tdata[4*C-1:3*C];
            in_color_reg <= s_tdata[4*C+COLOR_BITS-1:4*C];
        end
    end

    // line state
    logic [1:0]             mode_reg;
    logic signed [C-1:0]    cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    logic [C-1:0]           abs_dx_reg;
    logic signed [C:0]      neg_dy_reg;
    logic                   dir_x_neg_reg, dir_y_neg_reg;
    logic signed [EW-1:0]   err_reg;
    logic [COLOR_BITS-1:0]  color_reg;

    // screen size
    logic signed [XW-1:0]   scr_w, scr_h;
    assign scr_w = rot_reg[0] ? XW'({1'b0, nat_h_reg}) : XW'({1'b0, nat_w_reg});
    assign scr_h = rot_reg[0] ? XW'({1'b0, nat_w_reg}) : XW'({1'b0, nat_h_reg});

    // start decode
    logic signed [XW-1:0]   x0_e, y0_e, x1_e, y1_e;
    logic signed [XW-1:0]   lo_x, hi_x, lo_y, hi_y;
    logic                   y_eq, x_eq;
    logic                   h_reject, h_beyond, v_reject, v_beyond;
    logic signed [C-1:0]    h_stop_x, v_stop_y;
    logic signed [C:0]      dx_full, ndy_full;
    logic [C-1:0]           st_abs_dx;
    logic signed [EW-1:0]   st_err;

    assign x0_e = XW'(in_x0_reg);
    assign y0_e = XW'(in_y0_reg);
    assign x1_e = XW'(in_x1_reg);
    assign y1_e = XW'(in_y1_reg);
    assign y_eq = (in_y0_reg == in_y1_reg);
    assign x_eq = (in_x0_reg == in_x1_reg);
    assign lo_x = (x0_e < x1_e) ? x0_e : x1_e;
    assign hi_x = (x0_e < x1_e) ? x1_e : x0_e;
    assign lo_y = (y0_e < y1_e) ? y0_e : y1_e;
    assign hi_y = (y0_e < y1_e) ? y1_e : y0_e;

    assign h_reject = (lo_x < 0) || (y0_e < 0) || (y0_e >= scr_h);
    assign h_beyond = (lo_x >= scr_w);
    assign v_reject = (lo_y < 0) || (x0_e < 0) || (x0_e >= scr_w);
    assign v_beyond = (lo_y >= scr_h);
    assign h_stop_x = (hi_x < scr_w - XW'(1)) ? hi_x[C-1:0] : scr_w[C-1:0] - C'(1);
    assign v_stop_y = (hi_y < scr_h - XW'(1)) ? hi_y[C-1:0] : scr_h[C-1:0] - C'(1);

    assign dx_full   = (in_x1_reg > in_x0_reg) ? ((C+1)'(in_x1_reg) - (C+1)'(in_x0_reg))
                                               : ((C+1)'(in_x0_reg) - (C+1)'(in_x1_reg));
    assign ndy_full  = (in_y1_reg > in_y0_reg) ? ((C+1)'(in_y0_reg) - (C+1)'(in_y1_reg))
                                               : ((C+1)'(in_y1_reg) - (C+1)'(in_y0_reg));
    assign st_abs_dx = dx_full[C-1:0];
    assign st_err    = EW'({1'b0, st_abs_dx}) + EW'(ndy_full);

    // effective line and emit
    logic                   is_start, start_err;
    logic [STATUS_BITS-1:0] start_status;
    logic [1:0]             e_mode;
    logic signed [C-1:0]    e_cx, e_cy, e_stx, e_sty;
    logic [C-1:0]           e_adx;
    logic signed [C:0]      e_ndy;
    logic                   e_dxn, e_dyn;
    logic signed [EW-1:0]   e_err;
    logic [COLOR_BITS-1:0]  e_color;

    logic [1:0]             mode_next;
    logic signed [C-1:0]    cur_x_next, cur_y_next;
    logic signed [EW-1:0]   err_next, err_mid;
    logic signed [EW:0]     e2;
    logic                   done, move_x, move_y, off_scr;
    logic signed [XW-1:0]   cx_e, cy_e;

    logic signed [C-1:0]    o_x_next, o_y_next;
    logic [COLOR_BITS-1:0]  o_color_next;
    logic                   o_valid_next, o_last_next;
    logic [STATUS_BITS-1:0] o_status_next;

    assign is_start = (in_op_reg == OP_START);

    always_comb begin
        start_err    = 1'b0;
        start_status = ST_INVALID;
        e_mode  = mode_reg;
        e_cx    = cur_x_reg;
        e_cy    = cur_y_reg;
        e_stx   = stop_x_reg;
        e_sty   = stop_y_reg;
        e_adx   = abs_dx_reg;
        e_ndy   = neg_dy_reg;
        e_dxn   = dir_x_neg_reg;
        e_dyn   = dir_y_neg_reg;
        e_err   = err_reg;
        e_color = color_reg;
        if (is_start) begin
            e_color = in_color_reg;
            if (y_eq) begin
                start_err    = h_reject || h_beyond;
                start_status = h_reject ? ST_INVALID : ST_NOTHING;
                e_mode = start_err ? MODE_IDLE : MODE_HRUN;
                e_cx   = lo_x[C-1:0];
                e_cy   = in_y0_reg;
                e_stx  = h_stop_x;
                e_sty  = in_y0_reg;
            end else if (x_eq) begin
                start_err    = v_reject || v_beyond;
                start_status = v_reject ? ST_INVALID : ST_NOTHING;
                e_mode = start_err ? MODE_IDLE : MODE_VRUN;
                e_cx   = in_x0_reg;
                e_cy   = lo_y[C-1:0];
                e_stx  = in_x0_reg;
                e_sty  = v_stop_y;
            end else begin
                e_mode = MODE_SLOPE;
                e_cx   = in_x0_reg;
                e_cy   = in_y0_reg;
                e_stx  = in_x1_reg;
                e_sty  = in_y1_reg;
                e_adx  = st_abs_dx;
                e_ndy  = ndy_full;
                e_dxn  = !(in_x0_reg < in_x1_reg);
                e_dyn  = !(in_y0_reg < in_y1_reg);
                e_err  = st_err;
            end
        end
    end

    assign cx_e    = XW'(e_cx);
    assign cy_e    = XW'(e_cy);
    assign off_scr = (cx_e < 0) || (cx_e >= scr_w) || (cy_e < 0) || (cy_e >= scr_h);
    assign e2      = (EW+1)'(e_err) <<< 1;

    always_comb begin
        mode_next     = e_mode;
        cur_x_next    = e_cx;
        cur_y_next    = e_cy;
        err_next      = e_err;
        err_mid       = e_err;
        done          = 1'b0;
        move_x        = 1'b0;
        move_y        = 1'b0;
        o_x_next      = e_cx;
        o_y_next      = e_cy;
        o_color_next  = e_color;
        o_valid_next  = 1'b1;
        o_last_next   = 1'b0;
        o_status_next = ST_PIXEL_OK;
        if (is_start && start_err) begin
            mode_next     = MODE_IDLE;
            o_x_next      = '0;
            o_y_next      = '0;
            o_valid_next  = 1'b0;
            o_last_next   = 1'b1;
            o_status_next = start_status;
        end else begin
            unique case (e_mode)
                MODE_IDLE: begin
                    o_x_next      = '0;
                    o_y_next      = '0;
                    o_color_next  = '0;
                    o_valid_next  = 1'b0;
                    o_status_next = ST_IDLE_STEP;
                end
                MODE_HRUN: begin
                    done = (e_cx >= e_stx);
                    if (!done) begin
                        cur_x_next = e_cx + C'(1);
                    end
                end
                MODE_VRUN: begin
                    done = (e_cy >= e_sty);
                    if (!done) begin
                        cur_y_next = e_cy + C'(1);
                    end
                end
                MODE_SLOPE: begin
                    if (off_scr) begin
                        mode_next     = MODE_IDLE;
                        o_x_next      = '0;
                        o_y_next      = '0;
                        o_valid_next  = 1'b0;
                        o_last_next   = 1'b1;
                        o_status_next = ST_INVALID;
                    end else if ((e_cx == e_stx) && (e_cy == e_sty)) begin
                        done = 1'b1;
                    end else begin
                        if (e2 >= (EW+1)'(e_ndy)) begin
                            if (e_cx == e_stx) begin
                                done = 1'b1;
                            end else begin
                                move_x = 1'b1;
                            end
                        end
                        if (move_x) begin
                            err_mid    = e_err + EW'(e_ndy);
                            cur_x_next = e_dxn ? (e_cx - C'(1)) : (e_cx + C'(1));
                        end
                        if (!done && (e2 <= $signed((EW+1)'({1'b0, e_adx})))) begin
                            if (e_cy == e_sty) begin
                                done = 1'b1;
                            end else begin
                                move_y = 1'b1;
                            end
                        end
                        err_next = move_y ? (err_mid + EW'({1'b0, e_adx})) : err_mid;
                        if (move_y) begin
                            cur_y_next = e_dyn ? (e_cy - C'(1)) : (e_cy + C'(1));
                        end
                    end
                end
                default: ;
            endcase
            if (done) begin
                mode_next   = MODE_IDLE;
                o_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= e_stx;
            stop_y_reg    <= e_sty;
            abs_dx_reg    <= e_adx;
            neg_dy_reg    <= e_ndy;
            dir_x_neg_reg <= e_dxn;
            dir_y_neg_reg <= e_dyn;
            err_reg       <= err_next;
            color_reg     <= e_color;
        end
    end

    // output register
    logic signed [C-1:0]    out_x_reg, out_y_reg;
    logic [COLOR_BITS-1:0]  out_color_reg;
    logic                   out_valid_reg, out_last_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_x_reg      <= o_x_next;
            out_y_reg      <= o_y_next;
            out_color_reg  <= o_color_next;
            out_valid_reg  <= o_valid_next;
            out_last_reg   <= o_last_next;
            out_status_reg <= o_status_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_DATA_W'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = {out_status_reg, out_valid_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/sv/clipped_line_rasterizer_unit_tb.sv -----
// Self-checking testbench for clipped_line_rasterizer_unit: drives line starts and
// steps on the input stream, predicts every pixel result and checks the output stream.
// Depends on clr_pkg and the clipped_line_rasterizer_unit RTL.
`default_nettype none

module clipped_line_rasterizer_unit_tb;
    import clr_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int IN_W       = 4 * CB + COLOR_BITS;
    localparam int OUT_W      = 2 * CB + COLOR_BITS;
    localparam int ITEMS_STEP = 220;

    typedef struct packed {
        logic [CB-1:0]         px;
        logic [CB-1:0]         py;
        logic [COLOR_BITS-1:0] color;
        logic                  valid;
        logic                  last;
        logic [1:0]            status;
    } pixel_res_t;

    class line_scoreboard;
        int unsigned  nat_w = 240;
        int unsigned  nat_h = 320;
        logic [1:0]   rot   = 2'd0;
        logic [1:0]   mode  = MODE_IDLE;
        int           cx, cy, ex, ey, adx, ndy, err;
        bit           xneg, yneg;
        logic [15:0]  color;
        pixel_res_t   expected_pixels[$];
        int unsigned  mismatches;

        function int screen_w();
            return rot[0] ? int'(nat_h) : int'(nat_w);
        endfunction

        function int screen_h();
            return rot[0] ? int'(nat_w) : int'(nat_h);
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                REG_NATIVE_WIDTH: begin
                    nat_w = val & 32'h7ff;
                end
                REG_NATIVE_HEIGHT: begin
                    nat_h = val & 32'h7ff;
                end
                REG_ROTATION: begin
                    rot = val[1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function pixel_res_t make_px(int x, int y, logic [15:0] c, bit v, bit l,
                                     logic [1:0] s);
            pixel_res_t r;
            r.px     = x[CB-1:0];
            r.py     = y[CB-1:0];
            r.color  = c;
            r.valid  = v;
            r.last   = l;
            r.status = s;
            return r;
        endfunction

        // emit the current pixel and advance along the line
        function pixel_res_t next_pixel();
            int x;
            int y;
            int e2;
            bit done;
            x = cx;
            y = cy;
            done = 0;
            if (mode == MODE_HRUN) begin
                if (x >= ex) done = 1; else cx = x + 1;
            end else if (mode == MODE_VRUN) begin
                if (y >= ey) done = 1; else cy = y + 1;
            end else begin
                if (x < 0 || x >= screen_w() || y < 0 || y >= screen_h()) begin
                    mode = MODE_IDLE;
                    return make_px(0, 0, color, 0, 1, ST_INVALID);
                end
                if (x == ex && y == ey) begin
                    done = 1;
                end else begin
                    e2 = 2 * err;
                    if (e2 >= ndy) begin
                        if (cx == ex) done = 1;
                        else begin
                            err += ndy;
                            cx += xneg ? -1 : 1;
                        end
                    end
                    if (!done && e2 <= adx) begin
                        if (cy == ey) done = 1;
                        else begin
                            err += adx;
                            cy += yneg ? -1 : 1;
                        end
                    end
                end
            end
            if (done) mode = MODE_IDLE;
            return make_px(x, y, color, 1, done, ST_PIXEL_OK);
        endfunction

        function void note_item(logic op, logic [CB-1:0] ax, logic [CB-1:0] ay,
                                logic [CB-1:0] bx, logic [CB-1:0] by, logic [15:0] col);
            int x0, y0, x1, y1, w, h, lo, hi;
            x0 = $signed(ax);
            y0 = $signed(ay);
            x1 = $signed(bx);
            y1 = $signed(by);
            w = screen_w();
            h = screen_h();
            if (op == OP_STEP) begin
                if (mode == MODE_IDLE)
                    expected_pixels.push_back(make_px(0, 0, 16'h0, 0, 0, ST_IDLE_STEP));
                else
                    expected_pixels.push_back(next_pixel());
                return;
            end
            color = col;
            mode = MODE_IDLE;
            if (y0 == y1) begin
                lo = (x0 < x1) ? x0 : x1;
                hi = (x0 < x1) ? x1 : x0;
                if (lo < 0 || y0 < 0 || y0 >= h) begin
                    expected_pixels.push_back(make_px(0, 0, color, 0, 1, ST_INVALID));
                    return;
                end
                if (lo >= w) begin
                    expected_pixels.push_back(make_px(0, 0, color, 0, 1, ST_NOTHING));
                    return;
                end
                cx = lo;
                cy = y0;
                ey = y0;
                ex = (hi < w - 1) ? hi : w - 1;
                mode = MODE_HRUN;
            end else if (x0 == x1) begin
                lo = (y0 < y1) ? y0 : y1;
                hi = (y0 < y1) ? y1 : y0;
                if (lo < 0 || x0 < 0 || x0 >= w) begin
                    expected_pixels.push_back(make_px(0, 0, color, 0, 1, ST_INVALID));
                    return;
                end
                if (lo >= h) begin
                    expected_pixels.push_back(make_px(0, 0, color, 0, 1, ST_NOTHING));
                    return;
                end
                cx = x0;
                cy = lo;
                ex = x0;
                ey = (hi < h - 1) ? hi : h - 1;
                mode = MODE_VRUN;
            end else begin
                adx  = (x1 > x0) ? x1 - x0 : x0 - x1;
                ndy  = (y1 > y0) ? y0 - y1 : y1 - y0;
                xneg = !(x0 < x1);
                yneg = !(y0 < y1);
                err  = adx + ndy;
                cx = x0;
                cy = y0;
                ex = x1;
                ey = y1;
                mode = MODE_SLOPE;
            end
            expected_pixels.push_back(next_pixel());
        endfunction

        function void check_pixel(pixel_res_t got);
            pixel_res_t exp_px;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: x=%0d y=%0d status=%0d",
                             $signed(got.px), $signed(got.py), got.status);
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.px !== exp_px.px || got.py !== exp_px.py || got.color !== exp_px.color ||
                got.valid !== exp_px.valid || got.last !== exp_px.last ||
                got.status !== exp_px.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected x=%0d y=%0d color=%h valid=%b last=%b status=%0d",
                             $signed(exp_px.px), $signed(exp_px.py), exp_px.color,
                             exp_px.valid, exp_px.last, exp_px.status);
                    $display("          got      x=%0d y=%0d color=%h valid=%b last=%b status=%0d",
                             $signed(got.px), $signed(got.py), got.color,
                             got.valid, got.last, got.status);
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    // first_x, first_y, second_x, second_y, draw_color (lowest bits first)
    logic [IN_W-1:0]          s_tdata;
    // opcode
    logic [0:0]               s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // pixel_x, pixel_y, pixel_color (lowest bits first)
    logic [OUT_W-1:0]         m_tdata;
    // pixel_valid, status (lowest bits first)
    logic [STATUS_BITS:0]     m_tuser;
    logic                     m_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    line_scoreboard sb = new();
    int unsigned    items_sent;
    int unsigned    idle_odds;
    bit             no_idle;

    clipped_line_rasterizer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        pixel_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.px     = m_tdata[CB-1:0];
            got.py     = m_tdata[2*CB-1:CB];
            got.color  = m_tdata[OUT_W-1:2*CB];
            got.valid  = m_tuser[0];
            got.status = m_tuser[STATUS_BITS:1];
            got.last   = m_tlast;
            sb.check_pixel(got);
        end
    end

    // output side: random stall bursts, one long hold-off to back up the pipe
    initial begin
        int unsigned hold;
        bit          long_done;
        hold = 0;
        long_done = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!long_done && items_sent >= 400) begin
                long_done = 1;
                hold = 80;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!no_idle && idle_odds != 0 &&
                         $urandom_range(0, 4 * idle_odds) == 0) begin
                hold = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic int clip_coord(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    // bias toward both screen edges to exercise clipping
    function automatic int near_coord(int lim);
        case ($urandom_range(0, 2))
            0: return int'($urandom_range(0, 6)) - 3;
            1: return clip_coord(lim + int'($urandom_range(0, 5)) - 3);
            default: return clip_coord(int'($urandom_range(0, lim + 5)) - 3);
        endcase
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic push_item(logic op, int x0, int y0, int x1, int y1, logic [15:0] col);
        if (!no_idle && idle_odds != 0 && $urandom_range(0, 4 * idle_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, x0[CB-1:0], y0[CB-1:0], x1[CB-1:0], y1[CB-1:0], col);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic step_item();
        push_item(OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                  16'($urandom));
    endtask

    task automatic draw_line(int x0, int y0, int x1, int y1, logic [15:0] col, int steps);
        push_item(OP_START, x0, y0, x1, y1, col);
        repeat (steps) step_item();
    endtask

    task automatic random_line();
        int x0, y0, x1, y1, w, h, kind, span, n;
        w = sb.screen_w();
        h = sb.screen_h();
        kind = $urandom_range(0, 99);
        x0 = near_coord(w);
        y0 = near_coord(h);
        x1 = clip_coord(x0 + int'($urandom_range(0, 24)) - 12);
        y1 = clip_coord(y0 + int'($urandom_range(0, 24)) - 12);
        if (kind >= 95) begin
            repeat ($urandom_range(1, 3)) step_item();
            return;
        end else if (kind >= 85) begin
            x0 = any_coord();
            y0 = any_coord();
            x1 = ($urandom_range(0, 2) == 0) ? x0 : any_coord();
            y1 = ($urandom_range(0, 2) == 0) ? y0 : any_coord();
        end else if (kind >= 79) begin
            x1 = x0;
            y1 = y0;
        end else if (kind >= 62) begin
            x1 = x0;
            y1 = clip_coord(y0 + int'($urandom_range(0, 40)) - 20);
        end else if (kind >= 45) begin
            y1 = y0;
            x1 = clip_coord(x0 + int'($urandom_range(0, 40)) - 20);
        end
        span = (abs_int(x1 - x0) > abs_int(y1 - y0)) ? abs_int(x1 - x0) : abs_int(y1 - y0);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span + 2) : span;
        if (n > 48) n = $urandom_range(0, 48);
        draw_line(x0, y0, x1, y1, 16'($urandom), n);
    endtask

    task automatic cfg_write(logic [1:0] idx, int unsigned val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(idx) << 2;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int unsigned cfg_w[6];
        int unsigned cfg_h[6];
        int unsigned cfg_rot[6];
        cfg_w   = '{16, 2047, 1, 0, 33, 240};
        cfg_h   = '{24, 2047, 1, 5, 9, 320};
        cfg_rot = '{1, 3, 2, 0, 3, 0};
        items_sent = 0;
        no_idle   = 0;
        idle_odds = 1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_START;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        step_item();
        draw_line(10, 10, 10, 10, 16'hffff, 1);
        draw_line(5, 5, 2, 5, 16'h0000, 3);
        draw_line(237, 7, 2047, 7, 16'h1234, 2);
        draw_line(-1, 4, 5, 4, 16'h5555, 0);
        draw_line(0, 320, 3, 320, 16'haaaa, 0);
        draw_line(240, 3, 300, 3, 16'h0f0f, 0);
        draw_line(4, 318, 4, 2047, 16'hf0f0, 1);
        draw_line(240, 0, 240, 5, 16'h8001, 0);
        draw_line(3, 320, 3, 400, 16'h7ffe, 0);
        draw_line(0, 0, 2, 1, 16'h00ff, 2);
        draw_line(239, 1, 241, 3, 16'hff00, 1);
        draw_line(0, 0, 3, 3, 16'h3c3c, 1);
        draw_line(2047, -2048, -2048, 2047, 16'haaaa, 0);
        draw_line(1, 3, 0, 0, 16'hc3c3, 3);

        while (items_sent < ITEMS_STEP) random_line();

        foreach (cfg_w[p]) begin
            drain();
            cfg_write(REG_NATIVE_WIDTH, cfg_w[p]);
            cfg_write(REG_NATIVE_HEIGHT, cfg_h[p]);
            cfg_write(REG_ROTATION, cfg_rot[p]);
            idle_odds = $urandom_range(0, 3);
            if (p == 5) no_idle = 1;
            while (items_sent < (p + 2) * ITEMS_STEP) random_line();
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
